// File: sv/cfa_pkg.sv
// Shared types, constants and helpers for the Coulomb field accumulator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cfa_pkg;

  localparam int CW  = 32;  // position and charge width
  localparam int FW  = 48;  // field width, Q7.40
  localparam int FRW = 6;   // fragment id width
  localparam int IW  = 6;   // slot index width on the ports
  localparam int ACW = 7;   // atom count register width

  // Request codes of the input channel.
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_POINT = 2'd1,
    REQ_INTER = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // One atom as held in a ring cell.
  typedef struct packed {
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [CW-1:0]  z;
    logic signed [CW-1:0]  q;
    logic        [FRW-1:0] frag;
    logic signed [FW-1:0]  fx;
    logic signed [FW-1:0]  fy;
    logic signed [FW-1:0]  fz;
    logic                  sat;
  } atom_t;

  // Status and result of the pair term unit.
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic                 sat;
    logic signed [FW-1:0] tx;
    logic signed [FW-1:0] ty;
    logic signed [FW-1:0] tz;
  } pair_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_SEEK,
    S_READ_SEEK,
    S_READ_OUT,
    S_PT_STEP,
    S_PT_WAIT,
    S_IF_TGT,
    S_IF_ZERO,
    S_IF_SRC,
    S_IF_WAIT,
    S_IF_BACK
  } ctl_state_t;

  typedef enum logic [2:0] {
    P_IDLE,
    P_MUL,
    P_SUM,
    P_SQRT,
    P_DMUL,
    P_DCHK,
    P_DIV,
    P_FIN
  } pair_state_t;

  // Saturating add of two fields; bit FW flags saturation.
  function automatic logic [FW:0] sat_add(logic signed [FW-1:0] a, logic signed [FW-1:0] b);
    logic [FW:0] s;
    s = {a[FW-1], a} + {b[FW-1], b};
    if (s[FW] != s[FW-1]) begin
      return {1'b1, s[FW], {(FW-1){~s[FW]}}};
    end
    return {1'b0, s[FW-1:0]};
  endfunction

endpackage

// File: sv/coulomb_field_accumulator.sv
// Coulomb field accumulator: a rotating ring of atom cells and one pair term unit.
// Load and read rotate the ring until the slot reaches the head; one pair term runs start,
// multiply, sum, 33-step sqrt, 33-step multiply, range check, 48-step divide, finish. Point
// charge walks the whole ring with a pair term per taking-part atom; inter-fragment, per target,
// fetches it, walks the ring from slot 0 over cross-fragment sources and writes the sum back.
// One item at a time; a read result waits in the output reg. Reset: synchronous, active low;
// clears fields, flags, count and ring alignment.
`timescale 1ns / 1ps

module coulomb_field_accumulator #(
  parameter int MAX_ATOMS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [cfa_pkg::IW-1:0]        in_atom_index,
  input  logic signed [cfa_pkg::CW-1:0] in_pos_x,
  input  logic signed [cfa_pkg::CW-1:0] in_pos_y,
  input  logic signed [cfa_pkg::CW-1:0] in_pos_z,
  input  logic signed [cfa_pkg::CW-1:0] in_charge,
  input  logic [cfa_pkg::FRW-1:0]       in_fragment_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cfa_pkg::IW-1:0]        out_index,
  output logic signed [cfa_pkg::FW-1:0] out_field_x,
  output logic signed [cfa_pkg::FW-1:0] out_field_y,
  output logic signed [cfa_pkg::FW-1:0] out_field_z,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cfa_pkg::ACW-1:0]       cfg_atom_count
);
  import cfa_pkg::*;

  localparam int SW = $clog2(MAX_ATOMS);
  localparam int NW = (SW + 1 > ACW) ? SW + 1 : ACW;
  localparam logic [NW-1:0] N_ATOMS   = NW'(MAX_ATOMS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_ATOMS - 1);

  ctl_state_t st_r, st_nxt;

  // Ring alignment: cell k holds slot (h_r + k) mod MAX_ATOMS.
  logic [SW-1:0]  h_r;
  logic [SW-1:0]  cnt_r;
  logic [NW-1:0]  ti_r;
  logic [ACW-1:0] atom_count_r;

  // Beat captured at accept: load record, point charge or read slot.
  logic [IW-1:0]        idx_r;
  logic signed [CW-1:0] lx_r, ly_r, lz_r, lq_r;
  logic [FRW-1:0]       lfrag_r;

  // Inter-fragment target and its running term sum.
  logic signed [CW-1:0] tgt_x_r, tgt_y_r, tgt_z_r;
  logic [FRW-1:0]       tfrag_r;
  logic signed [FW-1:0] tacc_x_r, tacc_y_r, tacc_z_r;
  logic                 tsat_r;

  logic                 out_valid_r;
  logic [IW-1:0]        out_index_r;
  logic signed [FW-1:0] out_fx_r, out_fy_r, out_fz_r;
  logic                 out_sat_r;

  atom_t     ring    [MAX_ATOMS];
  atom_t     ring_nb [MAX_ATOMS];
  atom_t     head, head_val, wr_rec, load_rec, upd_rec;
  pair_res_t pr;

  logic          acc, rot, wr, pstart;
  logic [NW-1:0] h_ext, n_eff, seek_tgt;
  logic          head_part, hit, src_ok, out_free, idx_in, cnt_last, inter_mode;
  req_t          req;

  logic signed [FW-1:0] add_x, add_y, add_z;
  logic                 add_sat;
  logic [FW:0]          ux, uy, uz, sx, sy, sz;

  assign head     = ring[0];
  assign acc      = in_valid && (st_r == S_IDLE);
  assign in_stall = st_r != S_IDLE;
  assign req      = req_t'(in_req_type);

  // Config must only be written while idle; the block does not enforce it and takes it at once.
  assign cfg_ready = 1'b1;

  assign h_ext     = NW'(h_r);
  assign n_eff     = (NW'(atom_count_r) > N_ATOMS) ? N_ATOMS : NW'(atom_count_r);
  assign head_part = h_ext < n_eff;
  assign src_ok    = head_part && (head.frag != tfrag_r);
  assign idx_in    = NW'(idx_r) < N_ATOMS;
  assign cnt_last  = cnt_r == LAST_SLOT;
  assign out_free  = !out_valid_r || !out_stall;
  assign hit       = h_ext == seek_tgt;

  always_comb begin
    unique case (st_r)
      S_LOAD_SEEK, S_READ_SEEK: seek_tgt = NW'(idx_r);
      S_IF_TGT, S_IF_BACK:      seek_tgt = ti_r;
      default:                  seek_tgt = '0;
    endcase
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          unique case (req)
            REQ_LOAD:  st_nxt = (NW'(in_atom_index) < N_ATOMS) ? S_LOAD_SEEK : S_IDLE;
            REQ_POINT: st_nxt = (n_eff == '0) ? S_IDLE : S_PT_STEP;
            REQ_INTER: st_nxt = (n_eff == '0) ? S_IDLE : S_IF_TGT;
            REQ_READ:  st_nxt = (NW'(in_atom_index) < N_ATOMS) ? S_READ_SEEK : S_READ_OUT;
            default:   st_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD_SEEK: if (hit) st_nxt = S_IDLE;
      S_READ_SEEK: if (hit) st_nxt = S_READ_OUT;
      S_READ_OUT:  if (out_free) st_nxt = S_IDLE;
      S_PT_STEP: begin
        if (head_part) st_nxt = S_PT_WAIT;
        else if (cnt_last) st_nxt = S_IDLE;
      end
      S_PT_WAIT:   if (pr.done) st_nxt = cnt_last ? S_IDLE : S_PT_STEP;
      S_IF_TGT:    if (hit) st_nxt = S_IF_ZERO;
      S_IF_ZERO:   if (h_r == '0) st_nxt = S_IF_SRC;
      S_IF_SRC: begin
        if (src_ok) st_nxt = S_IF_WAIT;
        else if (cnt_last) st_nxt = S_IF_BACK;
      end
      S_IF_WAIT:   if (pr.done) st_nxt = cnt_last ? S_IF_BACK : S_IF_SRC;
      S_IF_BACK:   if (hit) st_nxt = (ti_r + 1'b1 < n_eff) ? S_IF_TGT : S_IDLE;
      default:     st_nxt = S_IDLE;
    endcase
  end

  // Ring and pair unit controls.
  always_comb begin
    rot    = 1'b0;
    wr     = 1'b0;
    pstart = 1'b0;
    unique case (st_r)
      S_LOAD_SEEK: begin
        rot = !hit;
        wr  = hit;
      end
      S_READ_SEEK, S_IF_TGT: rot = !hit;
      S_IF_BACK: begin
        rot = !hit;
        wr  = hit;
      end
      S_IF_ZERO: rot = h_r != '0;
      S_PT_STEP: begin
        rot    = !head_part;
        pstart = head_part;
      end
      S_PT_WAIT: begin
        // Write back and rotate together: the tail cell takes the updated record.
        rot = pr.done;
        wr  = pr.done;
      end
      S_IF_SRC: begin
        rot    = !src_ok;
        pstart = src_ok;
      end
      S_IF_WAIT: rot = pr.done;
      default: begin
      end
    endcase
  end

  // Field update of the head atom: pair term for point charges, the target sum otherwise.
  always_comb begin
    if (st_r == S_PT_WAIT) begin
      add_x = pr.tx; add_y = pr.ty; add_z = pr.tz; add_sat = pr.sat;
    end else begin
      add_x = tacc_x_r; add_y = tacc_y_r; add_z = tacc_z_r; add_sat = tsat_r;
    end
    ux = sat_add(head.fx, add_x);
    uy = sat_add(head.fy, add_y);
    uz = sat_add(head.fz, add_z);
    upd_rec     = head;
    upd_rec.fx  = ux[FW-1:0];
    upd_rec.fy  = uy[FW-1:0];
    upd_rec.fz  = uz[FW-1:0];
    upd_rec.sat = head.sat | add_sat | ux[FW] | uy[FW] | uz[FW];

    load_rec      = '0;
    load_rec.x    = lx_r;
    load_rec.y    = ly_r;
    load_rec.z    = lz_r;
    load_rec.q    = lq_r;
    load_rec.frag = lfrag_r;

    wr_rec   = (st_r == S_LOAD_SEEK) ? load_rec : upd_rec;
    head_val = wr ? wr_rec : head;

    sx = sat_add(tacc_x_r, pr.tx);
    sy = sat_add(tacc_y_r, pr.ty);
    sz = sat_add(tacc_z_r, pr.tz);
  end

  always_comb begin
    for (int k = 0; k < MAX_ATOMS - 1; k++) ring_nb[k] = ring[k + 1];
    ring_nb[MAX_ATOMS - 1] = head_val;
  end

  for (genvar k = 0; k < MAX_ATOMS; k++) begin : g_cell
    cfa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (rot),
      .wr_en    ((k == 0) && wr),
      .nb_rec   (ring_nb[k]),
      .wr_rec   (wr_rec),
      .rec      (ring[k])
    );
  end

  // Point charge: d = atom - point. Inter-fragment: d = target - source, source charge.
  assign inter_mode = st_r == S_IF_SRC;

  cfa_pair u_pair (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pstart),
    .ax    (inter_mode ? tgt_x_r : head.x),
    .ay    (inter_mode ? tgt_y_r : head.y),
    .az    (inter_mode ? tgt_z_r : head.z),
    .bx    (inter_mode ? head.x : lx_r),
    .by    (inter_mode ? head.y : ly_r),
    .bz    (inter_mode ? head.z : lz_r),
    .q     (inter_mode ? head.q : lq_r),
    .res   (pr)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      h_r          <= '0;
      cnt_r        <= '0;
      ti_r         <= '0;
      atom_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (rot) h_r <= (h_r == LAST_SLOT) ? '0 : h_r + 1'b1;
      if (acc || (st_r == S_IF_ZERO)) begin
        cnt_r <= '0;
      end else if (rot && ((st_r == S_PT_STEP) || (st_r == S_PT_WAIT) ||
                           (st_r == S_IF_SRC) || (st_r == S_IF_WAIT))) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (acc) ti_r <= '0;
      else if ((st_r == S_IF_BACK) && hit) ti_r <= ti_r + 1'b1;
      if (cfg_valid && cfg_ready) atom_count_r <= cfg_atom_count;
      if ((st_r == S_READ_OUT) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      idx_r   <= in_atom_index;
      lx_r    <= in_pos_x;
      ly_r    <= in_pos_y;
      lz_r    <= in_pos_z;
      lq_r    <= in_charge;
      lfrag_r <= in_fragment_id;
    end
    if ((st_r == S_IF_TGT) && hit) begin
      tgt_x_r  <= head.x;
      tgt_y_r  <= head.y;
      tgt_z_r  <= head.z;
      tfrag_r  <= head.frag;
      tacc_x_r <= '0;
      tacc_y_r <= '0;
      tacc_z_r <= '0;
      tsat_r   <= 1'b0;
    end else if ((st_r == S_IF_WAIT) && pr.done) begin
      tacc_x_r <= sx[FW-1:0];
      tacc_y_r <= sy[FW-1:0];
      tacc_z_r <= sz[FW-1:0];
      tsat_r   <= tsat_r | pr.sat | sx[FW] | sy[FW] | sz[FW];
    end
    if ((st_r == S_READ_OUT) && out_free) begin
      out_index_r <= idx_r;
      out_fx_r    <= idx_in ? head.fx : '0;
      out_fy_r    <= idx_in ? head.fy : '0;
      out_fz_r    <= idx_in ? head.fz : '0;
      out_sat_r   <= idx_in && head.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_field_x   = out_fx_r;
  assign out_field_y   = out_fy_r;
  assign out_field_z   = out_fz_r;
  assign out_saturated = out_sat_r;

  // Hold the pair unit to one term at a time.
  a_pair_free: assert property (@(posedge clk) disable iff (!rst_n)
    pstart |-> !pr.busy)
    else $error("pair unit started while busy");

  // Raise a result only out of the read state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_READ_OUT))
    else $error("result raised outside read");

  // Combine a head write with a rotation only in the point-charge write back.
  a_wr_rot: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && rot) |-> (st_r == S_PT_WAIT))
    else $error("head write during rotation");

  // Keep the head slot inside the ring.
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    h_r <= LAST_SLOT)
    else $error("head slot out of range");

endmodule

// File: sv/cfa_cell.sv
// One ring cell of the Coulomb field accumulator: holds a single atom record.
// Depends on cfa_pkg for the atom record type.
`timescale 1ns / 1ps

module cfa_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  logic           wr_en,
  input  cfa_pkg::atom_t nb_rec,
  input  cfa_pkg::atom_t wr_rec,
  output cfa_pkg::atom_t rec
);
  import cfa_pkg::*;

  atom_t rec_r;

  // Shift takes the neighbor's record; a head write lands only when the ring holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.fx  <= '0;
      rec_r.fy  <= '0;
      rec_r.fz  <= '0;
      rec_r.sat <= 1'b0;
    end else if (shift_en) begin
      rec_r <= nb_rec;
    end else if (wr_en) begin
      rec_r <= wr_rec;
    end
  end

  assign rec = rec_r;

endmodule

// File: sv/cfa_pair.sv
// Pair term unit: q*d/|d|^3 per component with bit-serial sqrt, multiply and divide.
// Depends on cfa_pkg for the result struct, state type and widths.
`timescale 1ns / 1ps

module cfa_pair (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [cfa_pkg::CW-1:0]  ax,
  input  logic signed [cfa_pkg::CW-1:0]  ay,
  input  logic signed [cfa_pkg::CW-1:0]  az,
  input  logic signed [cfa_pkg::CW-1:0]  bx,
  input  logic signed [cfa_pkg::CW-1:0]  by,
  input  logic signed [cfa_pkg::CW-1:0]  bz,
  input  logic signed [cfa_pkg::CW-1:0]  q,
  output cfa_pkg::pair_res_t             res
);
  import cfa_pkg::*;

  localparam int MW    = CW;           // magnitude width
  localparam int PW    = 2 * MW;       // product width
  localparam int SW    = PW + 2;       // sum of three squares
  localparam int RTW   = SW / 2;       // root width
  localparam int REMW  = RTW + 3;      // sqrt remainder width
  localparam int DENW  = SW + RTW + 1; // S * r
  localparam int QW    = FW;           // quotient bits kept
  localparam int FRACS = 40;           // numerator scale 2^40
  localparam int NB    = QW - FRACS;   // numerator bits shifted in by the divider
  localparam int CNTW  = $clog2(QW);
  localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

  pair_state_t st_r, st_nxt;
  logic [CNTW-1:0] cnt_r;

  logic [MW-1:0]     dmag_r [3];
  logic              dneg_r [3];
  logic [MW-1:0]     qmag_r;
  logic              qneg_r;
  logic [PW-1:0]     sq_r   [3];
  logic [PW-1:0]     p_r    [3];
  logic [SW-1:0]     s_r;
  logic [SW-1:0]     rad_r;
  logic [REMW-1:0]   srem_r;
  logic [RTW-1:0]    root_r;
  logic [DENW-1:0]   den_r;
  logic [DENW-1:0]   mcand_r;
  logic [DENW-1:0]   rem_r  [3];
  logic [QW-1:0]     quo_r  [3];
  logic [NB-1:0]     nb_r   [3];
  logic              big_r  [3];
  logic              zero_r;

  logic signed [CW-1:0] av [3];
  logic signed [CW-1:0] bv [3];
  logic [CW:0]          dd [3];
  logic [MW-1:0]        dm [3];
  logic [CW:0]          qe;
  logic [MW-1:0]        qm;
  logic [SW-1:0]        s_sum;
  logic [REMW-1:0]      sq_cat;
  logic                 sq_ge;
  logic [DENW:0]        div_t [3];
  logic                 div_ge [3];
  logic                 last;

  always_comb begin
    av[0] = ax; av[1] = ay; av[2] = az;
    bv[0] = bx; bv[1] = by; bv[2] = bz;
    for (int c = 0; c < 3; c++) begin
      dd[c] = {av[c][CW-1], av[c]} - {bv[c][CW-1], bv[c]};
      dm[c] = dd[c][CW] ? MW'(-dd[c]) : dd[c][MW-1:0];
    end
    qe     = {q[CW-1], q};
    qm     = q[CW-1] ? MW'(-qe) : q[MW-1:0];
    s_sum  = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    sq_cat = {srem_r[REMW-3:0], rad_r[SW-1:SW-2]};
    sq_ge  = sq_cat >= REMW'({root_r, 2'b01});
    for (int c = 0; c < 3; c++) begin
      div_t[c]  = {rem_r[c], nb_r[c][NB-1]};
      div_ge[c] = div_t[c] >= {1'b0, den_r};
    end
  end

  always_comb begin
    unique case (st_r)
      P_SQRT:  last = cnt_r == CNTW'(RTW - 1);
      P_DMUL:  last = cnt_r == CNTW'(RTW - 1);
      P_DIV:   last = cnt_r == CNTW'(QW - 1);
      default: last = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      P_IDLE: if (start) st_nxt = P_MUL;
      P_MUL:  st_nxt = P_SUM;
      P_SUM:  st_nxt = (s_sum == '0) ? P_FIN : P_SQRT;
      P_SQRT: if (last) st_nxt = P_DMUL;
      P_DMUL: if (last) st_nxt = P_DCHK;
      P_DCHK: st_nxt = P_DIV;
      P_DIV:  if (last) st_nxt = P_FIN;
      P_FIN:  st_nxt = P_IDLE;
      default: st_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= P_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= (st_nxt != st_r) ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      P_IDLE: begin
        if (start) begin
          for (int c = 0; c < 3; c++) begin
            dmag_r[c] <= dm[c];
            dneg_r[c] <= dd[c][CW];
          end
          qmag_r <= qm;
          qneg_r <= q[CW-1];
        end
      end
      P_MUL: begin
        for (int c = 0; c < 3; c++) begin
          sq_r[c] <= dmag_r[c] * dmag_r[c];
          p_r[c]  <= dmag_r[c] * qmag_r;
        end
      end
      P_SUM: begin
        s_r    <= s_sum;
        rad_r  <= s_sum;
        srem_r <= '0;
        root_r <= '0;
        zero_r <= s_sum == '0;
      end
      P_SQRT: begin
        // One root bit per cycle; stage the multiplier operands behind it.
        rad_r   <= rad_r << 2;
        srem_r  <= sq_ge ? sq_cat - REMW'({root_r, 2'b01}) : sq_cat;
        root_r  <= {root_r[RTW-2:0], sq_ge};
        mcand_r <= DENW'(s_r);
        den_r   <= '0;
      end
      P_DMUL: begin
        if (root_r[0]) den_r <= den_r + mcand_r;
        mcand_r <= mcand_r << 1;
        root_r  <= root_r >> 1;
      end
      P_DCHK: begin
        for (int c = 0; c < 3; c++) begin
          big_r[c] <= {{(DENW + NB - PW){1'b0}}, p_r[c]} >= {den_r, {NB{1'b0}}};
          rem_r[c] <= DENW'(p_r[c] >> NB);
          nb_r[c]  <= p_r[c][NB-1:0];
          quo_r[c] <= '0;
        end
      end
      P_DIV: begin
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= div_ge[c] ? DENW'(div_t[c] - {1'b0, den_r}) : div_t[c][DENW-1:0];
          quo_r[c] <= {quo_r[c][QW-2:0], div_ge[c]};
          nb_r[c]  <= nb_r[c] << 1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result: clamp, apply sign, drop zero products and zero distance.
  logic [QW-1:0]        lim  [3];
  logic                 csat [3];
  logic [QW-1:0]        cmag [3];
  logic signed [QW-1:0] cval [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lim[c]  = (dneg_r[c] ^ qneg_r) ? LIM_NEG : LIM_POS;
      csat[c] = !zero_r && (big_r[c] || (quo_r[c] > lim[c]));
      cmag[c] = csat[c] ? lim[c] : quo_r[c];
      if (zero_r || (p_r[c] == '0)) cval[c] = '0;
      else cval[c] = (dneg_r[c] ^ qneg_r) ? -cmag[c] : cmag[c];
    end
    res.busy = st_r != P_IDLE;
    res.done = st_r == P_FIN;
    res.sat  = csat[0] | csat[1] | csat[2];
    res.tx   = cval[0];
    res.ty   = cval[1];
    res.tz   = cval[2];
  end

endmodule

// File: tb/tb_coulomb_field_accumulator.sv
// Self-checking testbench for coulomb_field_accumulator: random and directed requests
// with an exact integer field predictor. Depends on cfa_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_coulomb_field_accumulator;
  import cfa_pkg::*;

  typedef struct {
    req_t              req;
    logic [IW-1:0]     idx;
    logic signed [31:0] x, y, z, q;
    logic [FRW-1:0]    frag;
  } atom_req_t;

  typedef struct {
    logic [IW-1:0]        idx;
    logic signed [FW-1:0] fx, fy, fz;
    logic                 sat;
  } field_beat_t;

  localparam longint FMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint FMIN = -FMAX - 1;
  localparam int SLOTS = 64;

  // Holds the expected atom table and the reads still owed by the block.
  class field_board;
    longint px[SLOTS], py[SLOTS], pz[SLOTS], pq[SLOTS];
    bit [FRW-1:0] pf[SLOTS];
    longint fx[SLOTS], fy[SLOTS], fz[SLOTS];
    bit fs[SLOTS];
    int unsigned count;
    field_beat_t due[$];
    int errors;

    function longint clamp_add(longint a, longint b, ref bit sat);
      longint s;
      s = a + b;
      if (s > FMAX) begin
        sat = 1;
        return FMAX;
      end
      if (s < FMIN) begin
        sat = 1;
        return FMIN;
      end
      return s;
    endfunction

    function logic [63:0] magn(longint v);
      return v < 0 ? -v : v;
    endfunction

    // q*d/|d|^3 in Q7.40, truncated toward zero, added into acc.
    function void add_pair(longint d[3], longint q, ref longint acc[3], ref bit sat);
      logic [127:0] s, den, num, quo, tt, lim;
      logic [63:0] r, p;
      bit neg;
      longint v;
      s = 0;
      r = 0;
      for (int c = 0; c < 3; c++) s += {64'b0, magn(d[c])} * {64'b0, magn(d[c])};
      if (s == 0) return;
      for (int b = 34; b >= 0; b--) begin
        tt = {64'b0, r | (64'd1 << b)};
        if (s >= tt * tt) r = tt[63:0];
      end
      den = s * {64'b0, r};
      for (int c = 0; c < 3; c++) begin
        neg = (d[c] < 0) != (q < 0);
        lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
        p = magn(d[c]) * magn(q);
        num = {64'b0, p} << 40;
        quo = num / den;
        if (quo > lim) begin
          sat = 1;
          quo = lim;
        end
        if (p == 0) continue;
        v = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        acc[c] = clamp_add(acc[c], v, sat);
      end
    endfunction

    function void fold_in(int i, longint t[3], bit sat);
      fx[i] = clamp_add(fx[i], t[0], sat);
      fy[i] = clamp_add(fy[i], t[1], sat);
      fz[i] = clamp_add(fz[i], t[2], sat);
      if (sat) fs[i] = 1;
    endfunction

    function void note(atom_req_t j);
      int n;
      longint d[3], t[3];
      bit sat;
      field_beat_t e;
      n = count > SLOTS ? SLOTS : count;
      case (j.req)
        REQ_LOAD: begin
          px[j.idx] = j.x; py[j.idx] = j.y; pz[j.idx] = j.z; pq[j.idx] = j.q;
          pf[j.idx] = j.frag;
          fx[j.idx] = 0; fy[j.idx] = 0; fz[j.idx] = 0; fs[j.idx] = 0;
        end
        REQ_POINT: begin
          for (int i = 0; i < n; i++) begin
            t = '{0, 0, 0};
            sat = 0;
            d = '{px[i] - j.x, py[i] - j.y, pz[i] - j.z};
            add_pair(d, longint'(j.q), t, sat);
            fold_in(i, t, sat);
          end
        end
        REQ_INTER: begin
          for (int i = 0; i < n; i++) begin
            t = '{0, 0, 0};
            sat = 0;
            for (int k = 0; k < n; k++) begin
              if (pf[k] == pf[i]) continue;
              d = '{px[i] - px[k], py[i] - py[k], pz[i] - pz[k]};
              add_pair(d, pq[k], t, sat);
            end
            fold_in(i, t, sat);
          end
        end
        default: begin
          e.idx = j.idx;
          e.fx = fx[j.idx][FW-1:0];
          e.fy = fy[j.idx][FW-1:0];
          e.fz = fz[j.idx][FW-1:0];
          e.sat = fs[j.idx];
          due.push_back(e);
        end
      endcase
    endfunction

    function void check(field_beat_t a);
      field_beat_t e;
      if (due.size() == 0) begin
        $display("%0t: read beat with nothing owed, index %0d", $time, a.idx);
        errors++;
        return;
      end
      e = due.pop_front();
      if (a.idx !== e.idx) begin
        $display("%0t: index expected %0d actual %0d", $time, e.idx, a.idx);
        errors++;
      end
      if (a.fx !== e.fx) begin
        $display("%0t: field_x expected %h actual %h", $time, e.fx, a.fx);
        errors++;
      end
      if (a.fy !== e.fy) begin
        $display("%0t: field_y expected %h actual %h", $time, e.fy, a.fy);
        errors++;
      end
      if (a.fz !== e.fz) begin
        $display("%0t: field_z expected %h actual %h", $time, e.fz, a.fz);
        errors++;
      end
      if (a.sat !== e.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, e.sat, a.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_req_type = 0;
  logic [IW-1:0] in_atom_index = 0;
  logic signed [CW-1:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0, in_charge = 0;
  logic [FRW-1:0] in_fragment_id = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [IW-1:0] out_index;
  logic signed [FW-1:0] out_field_x, out_field_y, out_field_z;
  logic out_saturated;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [ACW-1:0] cfg_atom_count = 0;

  field_board sb = new;
  bit calm = 0;        // no gaps on either side while set
  bit hold_req = 0;    // asks the receiver for one long hold-off
  int hold_left = 0;

  always #6 clk = ~clk;

  coulomb_field_accumulator dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_atom_index,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_charge, .in_fragment_id,
    .out_valid, .out_stall, .out_index, .out_field_x, .out_field_y, .out_field_z,
    .out_saturated,
    .cfg_valid, .cfg_ready, .cfg_atom_count
  );

  // Receiver: random stalls, or one long hold-off counted here when asked.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_stall = 1;
      hold_left--;
    end else begin
      out_stall = (!calm && $urandom_range(0, 99) < 35);
    end
  end

  // Sample result beats on the rising edge.
  always @(posedge clk) begin
    field_beat_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.idx = out_index;
      a.fx = out_field_x;
      a.fy = out_field_y;
      a.fz = out_field_z;
      a.sat = out_saturated;
      sb.check(a);
    end
  end

  // Coordinates: mostly near the origin so fields stay meaningful, sometimes full range.
  function automatic logic signed [31:0] any_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
  endfunction

  function automatic logic signed [31:0] any_charge();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h800_0000)) - 32'sh400_0000;
  endfunction

  function automatic atom_req_t make_req(req_t r, int idx, int frag);
    atom_req_t j;
    j.req = r;
    j.idx = IW'(idx);
    j.x = any_coord();
    j.y = any_coord();
    j.z = any_coord();
    j.q = any_charge();
    j.frag = FRW'(frag);
    return j;
  endfunction

  function automatic atom_req_t atom_at(int idx, int x, int y, int z, int q, int frag);
    atom_req_t j;
    j.req = REQ_LOAD;
    j.idx = IW'(idx);
    j.x = x; j.y = y; j.z = z; j.q = q;
    j.frag = FRW'(frag);
    return j;
  endfunction

  // Drive one beat at the falling edge; hold it until accepted.
  task automatic push(atom_req_t j);
    if (!calm && $urandom_range(0, 99) < 35) begin
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_req_type = j.req;
    in_atom_index = j.idx;
    in_pos_x = j.x;
    in_pos_y = j.y;
    in_pos_z = j.z;
    in_charge = j.q;
    in_fragment_id = j.frag;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note(j);
  endtask

  // A read of slot 0 proves the block idle once its beat is back.
  task automatic settle();
    push(make_req(REQ_READ, 0, 0));
    @(negedge clk);
    in_valid = 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(int v);
    @(negedge clk);
    cfg_atom_count = ACW'(v);
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.count = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Random beats; inter-fragment only while the count is small.
  task automatic random_run(int items, bit with_inter);
    int k;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 9);
      if (k < 2) push(make_req(REQ_LOAD, $urandom_range(0, 63), $urandom_range(0, 63)));
      else if (k < 5) push(make_req(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 63)));
      else if (k < 7 || !with_inter) begin
        atom_req_t j;
        j = make_req(REQ_POINT, $urandom_range(0, 63), $urandom_range(0, 63));
        // sometimes sit the point charge right on an atom
        if ($urandom_range(0, 4) == 0) begin
          j.x = 32'(sb.px[0]); j.y = 32'(sb.py[0]); j.z = 32'(sb.pz[0]);
        end
        push(j);
      end else push(make_req(REQ_INTER, $urandom_range(0, 63), $urandom_range(0, 63)));
    end
  endtask

  initial begin
    atom_req_t j;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    set_count(0);

    // No atoms take part yet: point and inter-fragment change nothing.
    push(make_req(REQ_POINT, 0, 0));
    push(make_req(REQ_INTER, 63, 63));
    // Extremes: origin, one LSB apart (saturates), full-range corners, zero charge.
    push(atom_at(0, 0, 0, 0, 32'sh7FFF_FFFF, 0));
    push(atom_at(1, 1, 0, 0, 32'sh8000_0000, 63));
    push(atom_at(2, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 21));
    push(atom_at(3, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh100_0000, 42));
    push(make_req(REQ_LOAD, 4, 0));
    push(make_req(REQ_LOAD, 5, 63));
    push(make_req(REQ_LOAD, 6, 1));
    push(make_req(REQ_LOAD, 7, 2));
    push(make_req(REQ_LOAD, 63, 5));
    settle();
    set_count(8);
    j = make_req(REQ_POINT, 0, 0);
    j.x = 32'(sb.px[4]); j.y = 32'(sb.py[4]); j.z = 32'(sb.pz[4]);
    push(j);
    push(make_req(REQ_POINT, 0, 0));
    push(make_req(REQ_INTER, 0, 0));
    for (int i = 0; i < 4; i++) push(make_req(REQ_READ, i, 0));
    push(make_req(REQ_READ, 63, 0));

    // Fill every slot; one fragment for most keeps the full-size pair walk short.
    for (int i = 0; i < SLOTS; i++)
      push(make_req(REQ_LOAD, i, i < 4 ? $urandom_range(0, 63) : 5));
    settle();
    set_count(64);
    push(make_req(REQ_INTER, 0, 0));
    random_run(8, 0);
    settle();
    set_count(127);
    random_run(8, 0);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      set_count(ph == 4 ? 0 : $urandom_range(1, 8));
      calm = (ph == 2);
      if (ph == 1) begin
        // long receiver hold while reads keep coming: the block backs up
        hold_req = 1;
        for (int i = 0; i < 6; i++) push(make_req(REQ_READ, $urandom_range(0, 63), 0));
        @(negedge clk);
        in_valid = 0;
        while (sb.due.size() != 0) @(posedge clk);
      end
      random_run(ph == 2 ? 12 : 6, 1);
      calm = 0;
    end

    @(negedge clk);
    in_valid = 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("coulomb_field_accumulator regression: pass");
    else $display("coulomb_field_accumulator regression: fail");
    $finish;
  end

  initial begin
    #60ms;
    $display("coulomb_field_accumulator regression: fail");
    $finish;
  end

endmodule
